// ----- sv/omni_chassis_wheel_mixer_defines.svh -----
// Assertion macros for the chassis wheel mixer.
// Depends on clk and rst_n being visible in the including module.
`ifndef OMNI_CHASSIS_WHEEL_MIXER_DEFINES_SVH
`define OMNI_CHASSIS_WHEEL_MIXER_DEFINES_SVH

// check a property on every clock, skip while in reset
`define OCWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that a condition is followed on the next clock by another
`define OCWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/ocwm_pkg.sv -----
// Types, constants and the arctangent table of the chassis wheel mixer.
// No dependencies.
package ocwm_pkg;

  localparam int TRIG_BITS       = 16;
  localparam int TRIG_F          = TRIG_BITS - 1;
  localparam int CORDIC_STEPS    = 30;
  localparam int STEPS_PER_STAGE = 4;
  localparam int CORDIC_STAGES   = (CORDIC_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int XW              = 34;
  localparam int ROUND_SH        = 30 - TRIG_F;
  localparam int PW              = 16 + TRIG_BITS;
  localparam int SW              = PW + 1;
  localparam int RXW             = 18;
  localparam int WW              = RXW + 2;
  localparam int LIM_W           = 15;
  localparam int CFG_IDX_W       = 2;

  localparam logic signed [XW-1:0] CORDIC_GAIN  = XW'(64'sd652032874);
  localparam logic signed [XW-1:0] HALF_TURN    = XW'(64'sd2147483648);
  localparam logic signed [XW-1:0] ROUND_HALF   = XW'(64'sd1 <<< (ROUND_SH - 1));
  localparam logic signed [XW-1:0] TRIG_MAX     = XW'((64'sd1 <<< TRIG_F) - 64'sd1);
  localparam logic signed [XW-1:0] TRIG_MIN     = XW'(-(64'sd1 <<< TRIG_F));
  localparam logic signed [SW-1:0] TRUNC_BIAS   = SW'((64'sd1 <<< TRIG_F) - 64'sd1);
  localparam logic signed [15:0]   QUARTER_HDG  = 16'sd16384;
  localparam logic signed [15:0]   NQUARTER_HDG = -16'sd16384;

  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(7800);

  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LIMIT = 2'd1;

  localparam logic MODE_DIAG = 1'b0;
  localparam logic MODE_AXIS = 1'b1;

  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_rot;
    logic signed [15:0] heading;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] wheel_zero;
    logic signed [15:0] wheel_one;
    logic signed [15:0] wheel_two;
    logic signed [15:0] wheel_three;
    logic [3:0]         clamped;
  } out_beat_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [XW-1:0] z;
    logic signed [15:0]   vx;
    logic signed [15:0]   vy;
    logic signed [15:0]   rot;
    logic                 flip;
  } cordic_t;

  function automatic logic signed [XW-1:0] atan_f(input int i);
    logic signed [XW-1:0] r;
    case (i)
      0:       r = XW'(64'sd536870912);
      1:       r = XW'(64'sd316933406);
      2:       r = XW'(64'sd167458907);
      3:       r = XW'(64'sd85004756);
      4:       r = XW'(64'sd42667331);
      5:       r = XW'(64'sd21354465);
      6:       r = XW'(64'sd10679838);
      7:       r = XW'(64'sd5340245);
      8:       r = XW'(64'sd2670163);
      9:       r = XW'(64'sd1335087);
      10:      r = XW'(64'sd667544);
      11:      r = XW'(64'sd333772);
      12:      r = XW'(64'sd166886);
      13:      r = XW'(64'sd83443);
      14:      r = XW'(64'sd41722);
      15:      r = XW'(64'sd20861);
      16:      r = XW'(64'sd10430);
      17:      r = XW'(64'sd5215);
      18:      r = XW'(64'sd2608);
      19:      r = XW'(64'sd1304);
      20:      r = XW'(64'sd652);
      21:      r = XW'(64'sd326);
      22:      r = XW'(64'sd163);
      23:      r = XW'(64'sd81);
      24:      r = XW'(64'sd41);
      25:      r = XW'(64'sd20);
      26:      r = XW'(64'sd10);
      27:      r = XW'(64'sd5);
      28:      r = XW'(64'sd3);
      29:      r = XW'(64'sd1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/omni_chassis_wheel_mixer.sv -----
// Chassis wheel mixer: heading rotation by pipelined CORDIC, mix and saturation.
// Depends on ocwm_pkg and omni_chassis_wheel_mixer_defines.svh.
//
//   channel   direction   handshake          payload
//   in_       input       valid / stall      in_beat_t  (vel_x, vel_y, vel_rot, heading)
//   out_      output      valid / stall      out_beat_t (four wheels, clamped)
//   cfg_      input       valid / ready      cfg_index, cfg_data
//
// One beat per cycle while in_stall is low. Pipe: input stage, 8 CORDIC stages of up to 4
// micro-rotations each (30 in all), round, multiply, sum, mix and output stage.
// Reset restores drive_mode 0 and target_limit 7800 and empties every stage.
// A one-beat skid behind the pipe absorbs out_stall; in_stall follows the skid.
`include "omni_chassis_wheel_mixer_defines.svh"

module omni_chassis_wheel_mixer
  import ocwm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_beat_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_beat_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIM_W-1:0]     cfg_data
);

  logic             mode_r;
  logic [LIM_W-1:0] limit_r;
  logic             en;

  cordic_t p0_r, p0_nxt;
  logic    p0_v_r;

  cordic_t cs_r   [CORDIC_STAGES];
  cordic_t cs_nxt [CORDIC_STAGES];
  cordic_t src_w  [CORDIC_STAGES];
  logic    cs_v_r [CORDIC_STAGES];

  logic signed [TRIG_BITS-1:0] cos_r, sin_r, cos_nxt, sin_nxt;
  logic signed [15:0]          rvx_r, rvy_r, rrot_r;
  logic                        rd_v_r;

  logic signed [PW-1:0] pxc_r, pys_r, pxs_r, pyc_r;
  logic signed [15:0]   mrot_r;
  logic                 m_v_r;

  logic signed [RXW-1:0] rx_r, ry_r, rx_nxt, ry_nxt;
  logic signed [15:0]    trot_r;
  logic                  t_v_r;

  out_beat_t l_r, l_nxt;
  logic      l_v_r;

  out_beat_t out_r, skid_r;
  logic      out_v_r, skid_v_r;
  logic      leave;
  logic      out_free;
  logic      w0_clamp_ok;

  assign cfg_ready = 1'b1;
  assign en        = !skid_v_r;
  assign in_stall  = skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_r;
  assign leave     = en && l_v_r;
  assign out_free  = !out_v_r || !out_stall;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_DIAG;
      limit_r <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DRIVE_MODE:   mode_r  <= cfg_data[0];
        CFG_TARGET_LIMIT: limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // fold heading into +/- quarter turn
  always_comb begin
    logic signed [XW-1:0] hz;
    hz            = {{(XW-32){in_data.heading[15]}}, in_data.heading, 16'b0};
    p0_nxt.x      = CORDIC_GAIN;
    p0_nxt.y      = '0;
    p0_nxt.vx     = in_data.vel_x;
    p0_nxt.vy     = in_data.vel_y;
    p0_nxt.rot    = in_data.vel_rot;
    p0_nxt.z      = hz;
    p0_nxt.flip   = 1'b0;
    if (in_data.heading > QUARTER_HDG) begin
      p0_nxt.z    = hz - HALF_TURN;
      p0_nxt.flip = 1'b1;
    end else if (in_data.heading < NQUARTER_HDG) begin
      p0_nxt.z    = hz + HALF_TURN;
      p0_nxt.flip = 1'b1;
    end
  end

  // CORDIC stages
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    if (g == 0) begin : g_first
      assign src_w[g] = p0_r;
    end else begin : g_rest
      assign src_w[g] = cs_r[g-1];
    end

    always_comb begin
      cordic_t              t;
      logic signed [XW-1:0] dx;
      logic signed [XW-1:0] dy;
      t = src_w[g];
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
        if (g * STEPS_PER_STAGE + j < CORDIC_STEPS) begin
          dx = $signed(t.y) >>> (g * STEPS_PER_STAGE + j);
          dy = $signed(t.x) >>> (g * STEPS_PER_STAGE + j);
          if (!t.z[XW-1]) begin
            t.x = t.x - dx;
            t.y = t.y + dy;
            t.z = t.z - atan_f(g * STEPS_PER_STAGE + j);
          end else begin
            t.x = t.x + dx;
            t.y = t.y - dy;
            t.z = t.z + atan_f(g * STEPS_PER_STAGE + j);
          end
        end
      end
      cs_nxt[g] = t;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cs_v_r[g] <= 1'b0;
      end else if (en) begin
        cs_v_r[g] <= (g == 0) ? p0_v_r : cs_v_r[(g == 0) ? 0 : g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cs_r[g] <= cs_nxt[g];
      end
    end
  end

  // undo fold, round and saturate sine and cosine
  always_comb begin
    cordic_t              f;
    logic signed [XW-1:0] xf, yf, xs, ys;
    f  = cs_r[CORDIC_STAGES-1];
    xf = f.flip ? -f.x : f.x;
    yf = f.flip ? -f.y : f.y;
    xs = (xf + ROUND_HALF) >>> ROUND_SH;
    ys = (yf + ROUND_HALF) >>> ROUND_SH;
    if (xs > TRIG_MAX) xs = TRIG_MAX;
    if (xs < TRIG_MIN) xs = TRIG_MIN;
    if (ys > TRIG_MAX) ys = TRIG_MAX;
    if (ys < TRIG_MIN) ys = TRIG_MIN;
    cos_nxt = xs[TRIG_BITS-1:0];
    sin_nxt = ys[TRIG_BITS-1:0];
  end

  // rotate: sum products and truncate toward zero
  always_comb begin
    logic signed [SW-1:0] sx, sy, tx, ty;
    sx     = SW'(pxc_r) - SW'(pys_r);
    sy     = SW'(pxs_r) + SW'(pyc_r);
    tx     = sx[SW-1] ? ((sx + TRUNC_BIAS) >>> TRIG_F) : (sx >>> TRIG_F);
    ty     = sy[SW-1] ? ((sy + TRUNC_BIAS) >>> TRIG_F) : (sy >>> TRIG_F);
    rx_nxt = tx[RXW-1:0];
    ry_nxt = ty[RXW-1:0];
  end

  // mix and saturate
  always_comb begin
    logic signed [WW-1:0] w [4];
    logic signed [WW-1:0] rx, ry, rot, lim;
    rx  = WW'(rx_r);
    ry  = WW'(ry_r);
    rot = WW'(trot_r);
    lim = $signed({{(WW-LIM_W){1'b0}}, limit_r});
    case (mode_r)
      MODE_DIAG: begin
        w[0] = rx + ry + rot;
        w[1] = rx - ry + rot;
        w[2] = -rx - ry + rot;
        w[3] = -rx + ry + rot;
      end
      default: begin
        w[0] = rx + rot;
        w[1] = -ry + rot;
        w[2] = -rx + rot;
        w[3] = ry + rot;
      end
    endcase
    l_nxt.clamped = '0;
    for (int k = 0; k < 4; k++) begin
      if (w[k] > lim) begin
        w[k] = lim;
        l_nxt.clamped[k] = 1'b1;
      end else if (w[k] < -lim) begin
        w[k] = -lim;
        l_nxt.clamped[k] = 1'b1;
      end
    end
    l_nxt.wheel_zero  = w[0][15:0];
    l_nxt.wheel_one   = w[1][15:0];
    l_nxt.wheel_two   = w[2][15:0];
    l_nxt.wheel_three = w[3][15:0];
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_v_r <= 1'b0;
      rd_v_r <= 1'b0;
      m_v_r  <= 1'b0;
      t_v_r  <= 1'b0;
      l_v_r  <= 1'b0;
    end else if (en) begin
      p0_v_r <= in_valid;
      rd_v_r <= cs_v_r[CORDIC_STAGES-1];
      m_v_r  <= rd_v_r;
      t_v_r  <= m_v_r;
      l_v_r  <= t_v_r;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (en) begin
      p0_r   <= p0_nxt;
      cos_r  <= cos_nxt;
      sin_r  <= sin_nxt;
      rvx_r  <= cs_r[CORDIC_STAGES-1].vx;
      rvy_r  <= cs_r[CORDIC_STAGES-1].vy;
      rrot_r <= cs_r[CORDIC_STAGES-1].rot;
      pxc_r  <= PW'(rvx_r) * PW'(cos_r);
      pys_r  <= PW'(rvy_r) * PW'(sin_r);
      pxs_r  <= PW'(rvx_r) * PW'(sin_r);
      pyc_r  <= PW'(rvy_r) * PW'(cos_r);
      mrot_r <= rrot_r;
      rx_r   <= rx_nxt;
      ry_r   <= ry_nxt;
      trot_r <= mrot_r;
      l_r    <= l_nxt;
    end
  end

  // output register and skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_free) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= leave;
      end
    end else if (leave) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_v_r ? skid_r : l_r;
    end else if (leave) begin
      skid_r <= l_r;
    end
  end

  assign w0_clamp_ok = !out_r.clamped[0] ||
                       (out_r.wheel_zero == $signed({1'b0, limit_r})) ||
                       (out_r.wheel_zero == -$signed({1'b0, limit_r}));

  `OCWM_ASSERT(a_skid_needs_out, skid_v_r |-> out_v_r, "skid full while output empty")
  `OCWM_ASSERT_NEXT(a_skid_drains, skid_v_r && !out_stall, !skid_v_r, "skid did not drain")
  `OCWM_ASSERT(a_clamp_at_bound, out_v_r |-> w0_clamp_ok, "clamped wheel not at bound")

endmodule

// ----- tb/sv/wheel_target_checker.sv -----
`timescale 1ns / 100ps
// Checker for the chassis wheel mixer: watches the command, result and register channels,
// predicts the four wheel targets and the clamp flags, and compares them in order.
// Depends on ocwm_pkg for the beat types, register indexes and reset values.
module wheel_target_checker
  import ocwm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_beat_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_beat_t            out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LIM_W-1:0]     cfg_data,
  output int                   mismatch_count,
  output int                   targets_pending
);

  localparam int     ROT_STEPS  = 30;
  localparam int     Q_FRAC     = 15;
  localparam longint GAIN_Q30   = 64'sd652032874;
  localparam longint QUARTER_Z  = 64'sd1073741824;
  localparam longint HALF_Z     = 64'sd2147483648;
  localparam longint TRIG_HI    = 64'sd32767;
  localparam longint TRIG_LO    = -64'sd32768;

  longint turn_angle [ROT_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1
  };

  logic            mode_sel;
  logic [LIM_W-1:0] limit_reg;
  out_beat_t       wheel_targets_q [$];

  function automatic longint round_q15(input longint v);
    longint r;
    r = (v + (64'sd1 <<< (30 - Q_FRAC - 1))) >>> (30 - Q_FRAC);
    if (r > TRIG_HI) r = TRIG_HI;
    if (r < TRIG_LO) r = TRIG_LO;
    return r;
  endfunction

  function automatic longint drop_q15(input longint v);
    if (v >= 0) return v >>> Q_FRAC;
    return -((-v) >>> Q_FRAC);
  endfunction

  function automatic void heading_trig(input logic signed [15:0] hdg,
                                       output longint sin_q, output longint cos_q);
    longint x, y, z, dx, dy;
    bit     flip;
    int     i;
    z    = longint'(hdg) * 64'sd65536;
    flip = 1'b0;
    if (z > QUARTER_Z) begin
      z    = z - HALF_Z;
      flip = 1'b1;
    end else if (z < -QUARTER_Z) begin
      z    = z + HALF_Z;
      flip = 1'b1;
    end
    x = GAIN_Q30;
    y = 0;
    for (i = 0; i < ROT_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - turn_angle[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + turn_angle[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cos_q = round_q15(x);
    sin_q = round_q15(y);
  endfunction

  function automatic out_beat_t predict_wheels(input in_beat_t cmd);
    longint    s, c, rx, ry, rot, lim;
    longint    w [4];
    logic [3:0] clamp;
    out_beat_t r;
    int        k;
    heading_trig(cmd.heading, s, c);
    rx  = drop_q15(longint'(cmd.vel_x) * c - longint'(cmd.vel_y) * s);
    ry  = drop_q15(longint'(cmd.vel_x) * s + longint'(cmd.vel_y) * c);
    rot = longint'(cmd.vel_rot);
    lim = longint'({1'b0, limit_reg});
    if (mode_sel == MODE_DIAG) begin
      w[0] = rx + ry + rot;
      w[1] = rx - ry + rot;
      w[2] = -rx - ry + rot;
      w[3] = -rx + ry + rot;
    end else begin
      w[0] = rx + rot;
      w[1] = -ry + rot;
      w[2] = -rx + rot;
      w[3] = ry + rot;
    end
    clamp = '0;
    for (k = 0; k < 4; k++) begin
      if (w[k] > lim) begin
        w[k]     = lim;
        clamp[k] = 1'b1;
      end else if (w[k] < -lim) begin
        w[k]     = -lim;
        clamp[k] = 1'b1;
      end
    end
    r.wheel_zero  = 16'(w[0]);
    r.wheel_one   = 16'(w[1]);
    r.wheel_two   = 16'(w[2]);
    r.wheel_three = 16'(w[3]);
    r.clamped     = clamp;
    return r;
  endfunction

  function automatic void check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      mode_sel  = MODE_DIAG;
      limit_reg = LIMIT_RESET;
      wheel_targets_q.delete();
      targets_pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DRIVE_MODE:   mode_sel  = cfg_data[0];
          CFG_TARGET_LIMIT: limit_reg = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (wheel_targets_q.size() == 0) begin
          $error("wheel beat with no command waiting");
          mismatch_count++;
        end else begin
          want = wheel_targets_q.pop_front();
          check_field("wheel_zero", longint'(want.wheel_zero), longint'(out_data.wheel_zero));
          check_field("wheel_one", longint'(want.wheel_one), longint'(out_data.wheel_one));
          check_field("wheel_two", longint'(want.wheel_two), longint'(out_data.wheel_two));
          check_field("wheel_three", longint'(want.wheel_three),
                      longint'(out_data.wheel_three));
          check_field("clamped", longint'(want.clamped), longint'(out_data.clamped));
        end
      end
      if (in_valid && !in_stall) wheel_targets_q.push_back(predict_wheels(in_data));
      targets_pending = wheel_targets_q.size();
    end
  end

endmodule

// ----- tb/sv/tb_omni_chassis_wheel_mixer.sv -----
`timescale 1ns / 100ps
// Top of the chassis wheel mixer testbench: clock, reset, command and register stimulus,
// receiver stall pattern, idle watchdog and verdict. Depends on ocwm_pkg, the mixer and
// wheel_target_checker.
module tb_omni_chassis_wheel_mixer;
  import ocwm_pkg::*;

  localparam int IDLE_LIMIT  = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_BEATS = 240;
  localparam int TAIL_CYCLES = 40;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_beat_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_beat_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [LIM_W-1:0]     cfg_data;

  int               mismatch_count;
  int               targets_pending;
  int               idle_cycles = 0;
  bit               hold_request = 1'b0;
  logic [LIM_W-1:0] cur_limit = LIMIT_RESET;

  omni_chassis_wheel_mixer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  wheel_target_checker u_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .targets_pending (targets_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: stall style changes per segment; a requested hold-off stalls for a long stretch
  initial begin
    int seg_len, style, tick;
    out_stall = 1'b0;
    forever begin
      seg_len = $urandom_range(10, 150);
      style   = $urandom_range(0, 3);
      for (tick = 0; tick < seg_len; tick++) begin
        @(negedge clk);
        if (hold_request) begin
          hold_request = 1'b0;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(negedge clk);
        end else begin
          case (style)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= (tick % 4 == 3);
          endcase
        end
      end
    end
  end

  function automatic in_beat_t cmd_of(input int vx, input int vy, input int rot, input int hdg);
    in_beat_t c;
    c.vel_x   = 16'(vx);
    c.vel_y   = 16'(vy);
    c.vel_rot = 16'(rot);
    c.heading = 16'(hdg);
    return c;
  endfunction

  function automatic logic signed [15:0] pick_speed();
    logic signed [15:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = 16'($urandom);
      4, 5, 6, 7: v = 16'(int'($urandom_range(0, 8000)) - 4000);
      8: begin
        case ($urandom_range(0, 4))
          0:       v = 16'sh7FFF;
          1:       v = 16'sh8000;
          2:       v = 16'sh0000;
          3:       v = 16'sh0001;
          default: v = 16'shFFFF;
        endcase
      end
      default: v = 16'(($urandom_range(0, 1) ? 1 : -1) * int'(cur_limit) +
                       int'($urandom_range(0, 2)) - 1);
    endcase
    return v;
  endfunction

  function automatic logic signed [15:0] pick_heading();
    logic signed [15:0] h;
    if ($urandom_range(0, 4) != 0) begin
      h = 16'($urandom);
    end else begin
      case ($urandom_range(0, 7))
        0:       h = 16'sd16384;
        1:       h = -16'sd16384;
        2:       h = 16'sd16385;
        3:       h = -16'sd16385;
        4:       h = 16'sh8000;
        5:       h = 16'sh7FFF;
        6:       h = 16'sd0;
        default: h = 16'sd8192;
      endcase
    end
    return h;
  endfunction

  function automatic in_beat_t rand_cmd();
    in_beat_t c;
    c.vel_x   = pick_speed();
    c.vel_y   = pick_speed();
    c.vel_rot = pick_speed();
    c.heading = pick_heading();
    return c;
  endfunction

  task automatic send_cmd(input in_beat_t cmd);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= cmd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_in(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_data  <= in_beat_t'({$urandom, $urandom});
    end
  endtask

  task automatic drain_targets();
    @(negedge clk);
    in_valid <= 1'b0;
    while (targets_pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIM_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_TARGET_LIMIT) cur_limit = val;
  endtask

  initial begin
    int               sent, burst, b;
    logic [LIM_W-1:0] lim;
    logic             mode_bit;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_DRIVE_MODE;
    cfg_data  = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: diagonal mix, default bound
    send_cmd(cmd_of(0, 0, 0, 0));
    send_cmd(cmd_of(32767, 32767, 32767, 0));
    send_cmd(cmd_of(-32768, -32768, -32768, -32768));
    send_cmd(cmd_of(0, 0, 7800, 0));
    send_cmd(cmd_of(0, 0, -7800, 0));
    send_cmd(cmd_of(0, 0, 7801, 0));
    send_cmd(cmd_of(0, 0, -7801, 0));
    send_cmd(cmd_of(1000, 0, 0, 16384));
    send_cmd(cmd_of(1000, 0, 0, 16385));
    send_cmd(cmd_of(1000, 0, 0, -16384));
    send_cmd(cmd_of(1000, 0, 0, -16385));
    send_cmd(cmd_of(1000, -700, 0, 32767));
    send_cmd(cmd_of(-32768, 32767, 0, 8192));
    drain_targets();

    write_reg(CFG_DRIVE_MODE, {14'h3FFF, MODE_AXIS});
    write_reg(CFG_TARGET_LIMIT, 15'h7FFF);
    send_cmd(cmd_of(32767, -32768, 32767, 0));
    send_cmd(cmd_of(-32768, 32767, -32768, -16385));
    send_cmd(cmd_of(0, 0, 32767, 0));
    send_cmd(cmd_of(100, -200, 300, 4000));
    drain_targets();

    // zero bound: every wheel forced to zero
    write_reg(CFG_TARGET_LIMIT, 15'h0000);
    send_cmd(cmd_of(0, 0, 0, 0));
    send_cmd(cmd_of(0, 0, 1, 0));
    send_cmd(cmd_of(-5, 7, 0, 1234));
    send_cmd(cmd_of(32767, 32767, 32767, 32767));
    drain_targets();

    // writes to unused indexes leave both registers alone
    write_reg(CFG_SPARE_A, 15'h5555);
    write_reg(CFG_SPARE_B, 15'h2AAA);
    cur_limit = 15'h0000;
    send_cmd(cmd_of(1200, -300, 50, 900));
    send_cmd(cmd_of(0, 0, -1, 0));
    drain_targets();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       lim = 15'h7FFF;
        1:       lim = 15'h0000;
        2:       lim = 15'h0001;
        3:       lim = LIMIT_RESET;
        default: lim = $urandom_range(0, 1) ? 15'($urandom) : 15'($urandom_range(0, 4000));
      endcase
      mode_bit = ph[0] ? MODE_AXIS : MODE_DIAG;
      write_reg(CFG_DRIVE_MODE, {14'($urandom), mode_bit});
      write_reg(CFG_TARGET_LIMIT, lim);
      sent = 0;
      if (ph == 3) begin
        hold_request = 1'b1;
        repeat (60) send_cmd(rand_cmd());
        sent = 60;
      end
      while (sent < PHASE_BEATS) begin
        burst = $urandom_range(1, 40);
        for (b = 0; b < burst && sent < PHASE_BEATS; b++) begin
          send_cmd(rand_cmd());
          sent++;
        end
        if (ph != 5) idle_in($urandom_range(0, 12));
      end
      drain_targets();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
